### rtl/i2a_pkg.sv
// ----------------------------------------------------------------------------
// i2a_pkg: shared types and constants for the integer to ASCII converter
// Word width, digit counts, radix and register codes, the queued word format.
// ----------------------------------------------------------------------------
package i2a_pkg;

  localparam int ValueWidth = 32;

  // Decimal digits needed for the largest unsigned word: floor(W*log10(2))+1.
  localparam int BcdDigits  = (ValueWidth * 30103) / 100000 + 1;
  localparam int BcdW       = 4 * BcdDigits;
  localparam int OctDigits  = (ValueWidth + 2) / 3;
  localparam int HexDigits  = (ValueWidth + 3) / 4;
  // The BCD image is the widest left-aligned digit image over the whole range.
  localparam int WorkW      = BcdW;
  localparam int CntW       = $clog2(ValueWidth + 1);
  localparam int CfgDataW   = 2;

  localparam logic [6:0] CharMinus = 7'h2D;
  localparam logic [6:0] CharZero  = 7'h30;
  localparam logic [6:0] CharLowA  = 7'h61;
  localparam logic [6:0] CharUpA   = 7'h41;

  typedef enum logic [1:0] {
    BaseBin = 2'd0,
    BaseOct = 2'd1,
    BaseDec = 2'd2,
    BaseHex = 2'd3
  } base_e;

  typedef enum logic [1:0] {
    CfgBaseSelect    = 2'd0,
    CfgSignedDecimal = 2'd1,
    CfgUpperCase     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    base_e                  base;
    logic                   negative;
    logic                   upper;
    logic [ValueWidth-1:0]  mag;
  } i2a_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } i2a_q_stat_t;

  function automatic logic [6:0] digit_char(logic [3:0] d, logic upper);
    logic [6:0] r;
    if (d < 4'd10) begin
      r = CharZero + 7'(d);
    end else begin
      r = (upper ? CharUpA : CharLowA) + 7'(d - 4'd10);
    end
    return r;
  endfunction

endpackage

### rtl/integer_to_ascii_digits.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_digits: binary word to ASCII digit stream
// Order: an accepted word passes the queue; the back then drives a '-' beat
//   first if negative, scans binary, octal or hex digits directly, and runs
//   double-dabble before scanning decimal. Digit positions: D = 32, 11, 8 for
//   binary, octal, hex, one scanned per cycle; 10 for decimal.
// Reset: decimal, unsigned, lower case; queue empty; no beat driven.
// ----------------------------------------------------------------------------
module integer_to_ascii_digits (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [i2a_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           start,
  output logic                           busy,
  input  logic [i2a_pkg::ValueWidth-1:0] value_i,
  output logic [6:0]                     character_o,
  output logic                           last_o,
  output logic                           strobe_o
);
  import i2a_pkg::*;

  // Front side: the queue decouples intake from digit generation, so a second
  // word is taken while the back is still printing the first.
  logic        push;
  logic        pop;
  logic        back_idle;
  i2a_item_t   front_item;
  i2a_item_t   q_item;
  i2a_q_stat_t q_stat;

  i2a_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .start_i    (start),
    .value_i    (value_i),
    .q_full_i   (q_stat.full),
    .push_o     (push),
    .item_o     (front_item)
  );

  i2a_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .pop_i  (pop),
    .item_o (q_item),
    .stat_o (q_stat)
  );

  // Back side: one beat per cycle at most, never held off by the receiver.
  i2a_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (q_item),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .idle_o      (back_idle),
    .character_o (character_o),
    .last_o      (last_o),
    .strobe_o    (strobe_o)
  );

  // Busy only while both queue slots hold words.
  assign busy = q_stat.full;

`ifndef SYNTHESIS
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && character_o == CharMinus |-> !last_o)
    else $error("minus sign marked as last beat");

  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> !q_stat.empty)
    else $error("accepted word missing from queue");

  a_no_spurious_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_idle && q_stat.empty |=> !strobe_o)
    else $error("beat without a queued word");
`endif

endmodule

### rtl/i2a_front.sv
// ----------------------------------------------------------------------------
// i2a_front: configuration registers and input classification
// Holds the radix and mode registers, takes words and pushes queue beats.
// ----------------------------------------------------------------------------
module i2a_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [i2a_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         start_i,
  input  logic [i2a_pkg::ValueWidth-1:0] value_i,
  input  logic                         q_full_i,
  output logic                         push_o,
  output i2a_pkg::i2a_item_t           item_o
);
  import i2a_pkg::*;

  base_e base_q, base_d;
  logic  sgn_q, sgn_d;
  logic  upper_q, upper_d;
  logic  negative;

  always_comb begin
    base_d  = base_q;
    sgn_d   = sgn_q;
    upper_d = upper_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgBaseSelect:    base_d  = base_e'(cfg_data_i[1:0]);
        CfgSignedDecimal: sgn_d   = cfg_data_i[0];
        CfgUpperCase:     upper_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= BaseDec;
      sgn_q   <= 1'b0;
      upper_q <= 1'b0;
    end else begin
      base_q  <= base_d;
      sgn_q   <= sgn_d;
      upper_q <= upper_d;
    end
  end

  // Negative only for signed decimal; the magnitude of the most negative word
  // still fits the unsigned width.
  assign negative        = (base_q == BaseDec) && sgn_q && value_i[ValueWidth-1];
  assign item_o.base     = base_q;
  assign item_o.negative = negative;
  assign item_o.upper    = upper_q;
  assign item_o.mag      = negative ? (~value_i + 1'b1) : value_i;
  assign push_o          = start_i && !q_full_i;

endmodule

### rtl/i2a_queue.sv
// ----------------------------------------------------------------------------
// i2a_queue: two-entry queue between front and back
// Decouples word intake from digit generation.
// ----------------------------------------------------------------------------
module i2a_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  i2a_pkg::i2a_item_t    item_i,
  input  logic                  pop_i,
  output i2a_pkg::i2a_item_t    item_o,
  output i2a_pkg::i2a_q_stat_t  stat_o
);
  import i2a_pkg::*;

  i2a_item_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= item_i;
  end

  assign item_o       = mem_q[rd_ptr_q];
  assign stat_o.empty = (cnt_q == 2'd0);
  assign stat_o.full  = (cnt_q == 2'd2);

endmodule

### rtl/i2a_back.sv
// ----------------------------------------------------------------------------
// i2a_back: digit generator
// Double-dabble for decimal, then a left-aligned digit scan, one digit a
// cycle, with leading zeros dropped.
// ----------------------------------------------------------------------------
module i2a_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  i2a_pkg::i2a_item_t   item_i,
  input  i2a_pkg::i2a_q_stat_t q_stat_i,
  output logic                 pop_o,
  output logic                 idle_o,
  output logic [6:0]           character_o,
  output logic                 last_o,
  output logic                 strobe_o
);
  import i2a_pkg::*;

  typedef enum logic [1:0] {StIdle, StDabble, StEmit} state_e;

  state_e                state_q, state_d;
  logic [WorkW-1:0]      work_q, work_d;
  logic [ValueWidth-1:0] bin_q, bin_d;
  logic [BcdW-1:0]       bcd_q, bcd_d, bcd_adj, bcd_step;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  seen_q, seen_d;
  base_e                 base_q, base_d;
  logic                  upper_q, upper_d;
  logic                  strobe_q, strobe_d;
  logic                  last_q, last_d;
  logic [6:0]            char_q, char_d;
  logic [3:0]            digit;

  function automatic logic [BcdW-1:0] bcd_adjust(logic [BcdW-1:0] b);
    logic [BcdW-1:0] r;
    r = b;
    for (int i = 0; i < BcdDigits; i++) begin
      if (b[4*i +: 4] >= 4'd5) r[4*i +: 4] = b[4*i +: 4] + 4'd3;
    end
    return r;
  endfunction

  assign bcd_adj  = bcd_adjust(bcd_q);
  assign bcd_step = {bcd_adj[BcdW-2:0], bin_q[ValueWidth-1]};

  // Top digit of the left-aligned image.
  always_comb begin
    case (base_q)
      BaseBin: digit = {3'b000, work_q[WorkW-1]};
      BaseOct: digit = {1'b0, work_q[WorkW-1 -: 3]};
      BaseDec: digit = work_q[WorkW-1 -: 4];
      BaseHex: digit = work_q[WorkW-1 -: 4];
    endcase
  end

  always_comb begin
    state_d  = state_q;
    work_d   = work_q;
    bin_d    = bin_q;
    bcd_d    = bcd_q;
    cnt_d    = cnt_q;
    seen_d   = seen_q;
    base_d   = base_q;
    upper_d  = upper_q;
    strobe_d = 1'b0;
    last_d   = 1'b0;
    char_d   = char_q;
    pop_o    = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (!q_stat_i.empty) begin
          pop_o   = 1'b1;
          base_d  = item_i.base;
          upper_d = item_i.upper;
          seen_d  = 1'b0;
          if (item_i.negative) begin
            strobe_d = 1'b1;
            char_d   = CharMinus;
          end
          case (item_i.base)
            BaseBin: begin
              work_d  = WorkW'(item_i.mag) << (WorkW - ValueWidth);
              cnt_d   = CntW'(ValueWidth);
              state_d = StEmit;
            end
            BaseOct: begin
              work_d  = WorkW'(item_i.mag) << (WorkW - 3 * OctDigits);
              cnt_d   = CntW'(OctDigits);
              state_d = StEmit;
            end
            BaseDec: begin
              bin_d   = item_i.mag;
              bcd_d   = '0;
              cnt_d   = CntW'(ValueWidth);
              state_d = StDabble;
            end
            BaseHex: begin
              work_d  = WorkW'(item_i.mag) << (WorkW - 4 * HexDigits);
              cnt_d   = CntW'(HexDigits);
              state_d = StEmit;
            end
          endcase
        end
      end
      StDabble: begin
        bcd_d = bcd_step;
        bin_d = bin_q << 1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          work_d  = WorkW'(bcd_step);
          cnt_d   = CntW'(BcdDigits);
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (digit != 4'd0 || seen_q || cnt_q == CntW'(1)) begin
          strobe_d = 1'b1;
          char_d   = digit_char(digit, upper_q);
          last_d   = (cnt_q == CntW'(1));
          seen_d   = 1'b1;
        end
        case (base_q)
          BaseBin: work_d = work_q << 1;
          BaseOct: work_d = work_q << 3;
          BaseDec: work_d = work_q << 4;
          BaseHex: work_d = work_q << 4;
        endcase
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      work_q   <= '0;
      bin_q    <= '0;
      bcd_q    <= '0;
      cnt_q    <= '0;
      seen_q   <= 1'b0;
      base_q   <= BaseDec;
      upper_q  <= 1'b0;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
      char_q   <= '0;
    end else begin
      state_q  <= state_d;
      work_q   <= work_d;
      bin_q    <= bin_d;
      bcd_q    <= bcd_d;
      cnt_q    <= cnt_d;
      seen_q   <= seen_d;
      base_q   <= base_d;
      upper_q  <= upper_d;
      strobe_q <= strobe_d;
      last_q   <= last_d;
      char_q   <= char_d;
    end
  end

  assign idle_o      = (state_q == StIdle);
  assign strobe_o    = strobe_q;
  assign last_o      = last_q;
  assign character_o = char_q;

endmodule
